// ===== rtl/rqht_pkg.sv =====
// ----------------------------------------------------------------------------
// rqht_pkg
// Widths, reset values, register codes and pipeline types of the ray/quad
// hit test.
// ----------------------------------------------------------------------------
package rqht_pkg;

   // field widths
   localparam int POS_W  = 32;
   localparam int QUAT_W = 18;
   localparam int HALF_W = 24;
   localparam int UV_W   = 17;
   localparam int CSR_W  = 32;

   // direction math
   localparam int PROD_W    = 2 * QUAT_W;
   localparam int DIR_W     = 38;
   localparam int DIR_SHIFT = 8;
   localparam int NUM_W     = POS_W + 1;
   localparam int ANUM_W    = POS_W;
   localparam int ADIR_W    = 29;
   localparam int ADZ_W     = 25;
   localparam int MUL_W     = ANUM_W + ADIR_W;
   localparam int DIVD_W    = 60;

   // divider cells
   localparam int REM_W    = 25;
   localparam int WORD_W   = 50;
   localparam int XY_CELLS = WORD_W;
   localparam int UV_CELLS = UV_W;

   // hit point
   localparam int HX_W = 53;

   localparam logic signed [DIR_W-1:0] DZ_LIMIT = -38'sd429497;
   localparam logic signed [DIR_W-1:0] DZ_BIAS  = 38'sd4294967296;
   localparam logic [UV_W-1:0]         UV_ONE   = 17'h10000;

   localparam logic [HALF_W-1:0]       HALF_WIDTH_RST  = 24'd39322;
   localparam logic [HALF_W-1:0]       HALF_HEIGHT_RST = 24'd26214;
   localparam logic signed [POS_W-1:0] CENTER_Y_RST    = 32'sd98304;
   localparam logic signed [POS_W-1:0] PLANE_Z_RST     = -32'sd91750;

   typedef enum logic [1:0] {
      CSR_HALF_WIDTH,
      CSR_HALF_HEIGHT,
      CSR_CENTER_Y,
      CSR_PLANE_Z
   } csr_index_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [REM_W-1:0]  dvs;
      logic [WORD_W-1:0] word;
   } div_stage_type;

   typedef struct packed {
      logic                    miss;
      logic                    sx;
      logic                    sy;
      logic signed [POS_W-1:0] ox;
      logic signed [POS_W-1:0] oy;
   } xy_side_type;

   typedef struct packed {
      logic          valid;
      xy_side_type   side;
      div_stage_type divx;
      div_stage_type divy;
   } front_out_type;

   typedef struct packed {
      logic          valid;
      logic          hit;
      div_stage_type divu;
      div_stage_type divv;
   } uv_stage_type;

   typedef struct packed {
      logic            hit;
      logic [UV_W-1:0] tex_u;
      logic [UV_W-1:0] tex_v;
   } result_type;

endpackage

// ===== rtl/rqht_req_if.sv =====
// ----------------------------------------------------------------------------
// rqht_req_if
// Request channel: ray origin and orientation quaternion.
// ----------------------------------------------------------------------------
interface rqht_req_if;
   import rqht_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  origin_x;
   logic signed [POS_W-1:0]  origin_y;
   logic signed [POS_W-1:0]  origin_z;
   logic signed [QUAT_W-1:0] quat_x;
   logic signed [QUAT_W-1:0] quat_y;
   logic signed [QUAT_W-1:0] quat_z;
   logic signed [QUAT_W-1:0] quat_w;

   modport source (
      output valid, origin_x, origin_y, origin_z, quat_x, quat_y, quat_z, quat_w,
      input  ready
   );

   modport sink (
      input  valid, origin_x, origin_y, origin_z, quat_x, quat_y, quat_z, quat_w,
      output ready
   );

endinterface

// ===== rtl/rqht_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rqht_rsp_if
// Response channel: hit flag and texture coordinates.
// ----------------------------------------------------------------------------
interface rqht_rsp_if;
   import rqht_pkg::*;

   logic            valid;
   logic            ready;
   logic            hit;
   logic [UV_W-1:0] tex_u;
   logic [UV_W-1:0] tex_v;

   modport source (
      output valid, hit, tex_u, tex_v,
      input  ready
   );

   modport sink (
      input  valid, hit, tex_u, tex_v,
      output ready
   );

endinterface

// ===== rtl/rqht_div_cell.sv =====
// ----------------------------------------------------------------------------
// rqht_div_cell
// One restoring-division cell: takes the next dividend bit off the top of
// the shift word, tries a subtract and shifts the quotient bit in below.
// ----------------------------------------------------------------------------
module rqht_div_cell (
   input  logic                    clock,
   input  logic                    adv,
   input  rqht_pkg::div_stage_type cell_in,
   output rqht_pkg::div_stage_type cell_out
);
   import rqht_pkg::*;

   logic [REM_W:0]   part;
   logic [REM_W+1:0] trial;
   logic             take;
   div_stage_type    stage_in;
   div_stage_type    stage_ff;

   assign part  = {cell_in.rem, cell_in.word[WORD_W-1]};
   assign trial = {1'b0, part} - {2'b00, cell_in.dvs};
   assign take  = ~trial[REM_W+1];

   always_comb begin
      stage_in.rem  = take ? trial[REM_W-1:0] : part[REM_W-1:0];
      stage_in.dvs  = cell_in.dvs;
      stage_in.word = {cell_in.word[WORD_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

endmodule

// ===== rtl/rqht_front.sv =====
// ----------------------------------------------------------------------------
// rqht_front
// Front end: quaternion products, ray direction, early miss tests and the
// distance-times-direction products that feed the x and y divider rows.
// ----------------------------------------------------------------------------
module rqht_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   rqht_req_if.sink                       req,
   input  logic signed [rqht_pkg::POS_W-1:0] plane_z,
   output rqht_pkg::front_out_type        front_out
);
   import rqht_pkg::*;

   // stage a: products
   logic                     va_ff;
   logic signed [PROD_W-1:0] pxz_ff, pwy_ff, pyz_ff, pwx_ff, pxx_ff, pyy_ff;
   logic signed [POS_W-1:0]  oxa_ff, oya_ff;
   logic signed [NUM_W-1:0]  numa_ff, numa_in;

   // stage b: direction
   logic                    vb_ff;
   logic                    missb_ff, missb_in;
   logic signed [DIR_W-1:0] dxb_ff, dyb_ff, dzb_ff;
   logic signed [DIR_W-1:0] dxb_in, dyb_in, dzb_in;
   logic signed [DIR_W-1:0] sum_dx, sum_dy, sum_dz;
   logic signed [POS_W-1:0] oxb_ff, oyb_ff;
   logic signed [NUM_W-1:0] numb_ff;

   // stage c: magnitudes
   logic                    vc_ff;
   logic                    missc_ff, sxc_ff, syc_ff;
   logic [ADIR_W-1:0]       adxc_ff, adyc_ff;
   logic [ADZ_W-1:0]        adzc_ff;
   logic [ANUM_W-1:0]       anumc_ff;
   logic signed [POS_W-1:0] oxc_ff, oyc_ff;
   logic signed [DIR_W-1:0] abs_dx, abs_dy, neg_dz;
   logic signed [NUM_W-1:0] neg_num;

   // stage d: products for the dividers
   logic [MUL_W-1:0] mulx, muly;
   front_out_type    front_ff, front_in;

   assign req.ready = adv & ~reset;

   assign numa_in = NUM_W'(plane_z) - NUM_W'(req.origin_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pxz_ff  <= PROD_W'(req.quat_x) * PROD_W'(req.quat_z);
         pwy_ff  <= PROD_W'(req.quat_w) * PROD_W'(req.quat_y);
         pyz_ff  <= PROD_W'(req.quat_y) * PROD_W'(req.quat_z);
         pwx_ff  <= PROD_W'(req.quat_w) * PROD_W'(req.quat_x);
         pxx_ff  <= PROD_W'(req.quat_x) * PROD_W'(req.quat_x);
         pyy_ff  <= PROD_W'(req.quat_y) * PROD_W'(req.quat_y);
         oxa_ff  <= req.origin_x;
         oya_ff  <= req.origin_y;
         numa_ff <= numa_in;
      end
   end

   // d = (-2(xz+wy), -2(yz-wx), 2(xx+yy)-1) in q.32
   assign sum_dx = DIR_W'(pxz_ff) + DIR_W'(pwy_ff);
   assign sum_dy = DIR_W'(pyz_ff) - DIR_W'(pwx_ff);
   assign sum_dz = DIR_W'(pxx_ff) + DIR_W'(pyy_ff);
   assign dxb_in = -(sum_dx + sum_dx);
   assign dyb_in = -(sum_dy + sum_dy);
   assign dzb_in = (sum_dz + sum_dz) - DZ_BIAS;
   // miss when not aimed toward -z or the plane lies behind the origin
   assign missb_in = (dzb_in >= DZ_LIMIT) || ~numa_ff[NUM_W-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         dxb_ff   <= dxb_in;
         dyb_ff   <= dyb_in;
         dzb_ff   <= dzb_in;
         missb_ff <= missb_in;
         numb_ff  <= numa_ff;
         oxb_ff   <= oxa_ff;
         oyb_ff   <= oya_ff;
      end
   end

   // truncation toward zero of the q.24 step is a shift of the magnitude
   assign abs_dx  = dxb_ff[DIR_W-1] ? -dxb_ff : dxb_ff;
   assign abs_dy  = dyb_ff[DIR_W-1] ? -dyb_ff : dyb_ff;
   assign neg_dz  = -dzb_ff;
   assign neg_num = -numb_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         adxc_ff  <= abs_dx[DIR_SHIFT +: ADIR_W];
         adyc_ff  <= abs_dy[DIR_SHIFT +: ADIR_W];
         adzc_ff  <= neg_dz[DIR_SHIFT +: ADZ_W];
         anumc_ff <= neg_num[ANUM_W-1:0];
         sxc_ff   <= dxb_ff[DIR_W-1];
         syc_ff   <= dyb_ff[DIR_W-1];
         missc_ff <= missb_ff;
         oxc_ff   <= oxb_ff;
         oyc_ff   <= oyb_ff;
      end
   end

   assign mulx = MUL_W'(anumc_ff) * MUL_W'(adxc_ff);
   assign muly = MUL_W'(anumc_ff) * MUL_W'(adyc_ff);

   always_comb begin
      front_in.valid     = vc_ff;
      front_in.side.miss = missc_ff;
      front_in.side.sx   = sxc_ff;
      front_in.side.sy   = syc_ff;
      front_in.side.ox   = oxc_ff;
      front_in.side.oy   = oyc_ff;
      front_in.divx.rem  = REM_W'(mulx[DIVD_W-1:WORD_W]);
      front_in.divx.dvs  = adzc_ff;
      front_in.divx.word = mulx[WORD_W-1:0];
      front_in.divy.rem  = REM_W'(muly[DIVD_W-1:WORD_W]);
      front_in.divy.dvs  = adzc_ff;
      front_in.divy.word = muly[WORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (adv) begin
         front_ff.valid <= front_in.valid;
      end
      if (adv) begin
         front_ff.side <= front_in.side;
         front_ff.divx <= front_in.divx;
         front_ff.divy <= front_in.divy;
      end
   end

   assign front_out = front_ff;

endmodule

// ===== rtl/rqht_bound.sv =====
// ----------------------------------------------------------------------------
// rqht_bound
// Hit point from the x and y quotients, rectangle bound test and setup of
// the u and v divider rows.
// ----------------------------------------------------------------------------
module rqht_bound (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              xy_valid,
   input  rqht_pkg::xy_side_type             side,
   input  logic [rqht_pkg::WORD_W-1:0]       quot_x,
   input  logic [rqht_pkg::WORD_W-1:0]       quot_y,
   input  logic [rqht_pkg::HALF_W-1:0]       half_width,
   input  logic [rqht_pkg::HALF_W-1:0]       half_height,
   input  logic signed [rqht_pkg::POS_W-1:0] center_y,
   output rqht_pkg::uv_stage_type            bound_out
);
   import rqht_pkg::*;

   logic                   ve_ff;
   logic                   misse_ff;
   logic signed [HX_W-1:0] hxe_ff, hye_ff, hx_in, hy_in;
   logic signed [HX_W-1:0] qx_s, qy_s;

   logic signed [HX_W-1:0] hw_s, hh_s, lo_y, hi_y, ofs_u, ofs_v;
   logic                   in_x, in_y;
   uv_stage_type           bound_ff, bound_in;

   assign qx_s  = $signed({{(HX_W-WORD_W){1'b0}}, quot_x});
   assign qy_s  = $signed({{(HX_W-WORD_W){1'b0}}, quot_y});
   assign hx_in = HX_W'(side.ox) + (side.sx ? -qx_s : qx_s);
   assign hy_in = HX_W'(side.oy) + (side.sy ? -qy_s : qy_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (adv) begin
         ve_ff <= xy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         misse_ff <= side.miss;
         hxe_ff   <= hx_in;
         hye_ff   <= hy_in;
      end
   end

   assign hw_s  = $signed({{(HX_W-HALF_W){1'b0}}, half_width});
   assign hh_s  = $signed({{(HX_W-HALF_W){1'b0}}, half_height});
   assign lo_y  = HX_W'(center_y) - hh_s;
   assign hi_y  = HX_W'(center_y) + hh_s;
   // edges count as inside
   assign in_x  = (hxe_ff >= -hw_s) && (hxe_ff <= hw_s);
   assign in_y  = (hye_ff >= lo_y) && (hye_ff <= hi_y);
   assign ofs_u = hxe_ff + hw_s;
   assign ofs_v = hye_ff - lo_y;

   // dividend is ofs << 16, seeded so that 17 cells leave the quotient
   always_comb begin
      bound_in.valid     = ve_ff;
      bound_in.hit       = ~misse_ff & in_x & in_y;
      bound_in.divu.rem  = {1'b0, ofs_u[REM_W-1:1]};
      bound_in.divu.dvs  = {half_width, 1'b0};
      bound_in.divu.word = {ofs_u[0], {(WORD_W-1){1'b0}}};
      bound_in.divv.rem  = {1'b0, ofs_v[REM_W-1:1]};
      bound_in.divv.dvs  = {half_height, 1'b0};
      bound_in.divv.word = {ofs_v[0], {(WORD_W-1){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff.valid <= 1'b0;
      end else if (adv) begin
         bound_ff.valid <= bound_in.valid;
      end
      if (adv) begin
         bound_ff.hit  <= bound_in.hit;
         bound_ff.divu <= bound_in.divu;
         bound_ff.divv <= bound_in.divv;
      end
   end

   assign bound_out = bound_ff;

endmodule

// ===== rtl/ray_quad_hit_test_top.sv =====
// ----------------------------------------------------------------------------
// ray_quad_hit_test_top
// Ray against axis-aligned rectangle hit test with texture coordinates.
// ----------------------------------------------------------------------------
// The block takes one request per clock while req.ready is high and returns
// one response per request, in order. The pipeline is made of two rows of
// division cells, one quotient bit per cell: 50 cells for the hit offset
// along x and y, then 17 cells for u and v, plus four front stages, two
// bound-test stages and the output register. The whole pipeline moves
// together; a skid register at the output holds one more result while a
// response waits, after which req.ready drops until the response side takes
// data. Registers are written through csr_* and must only change while no
// request is in flight.
// ----------------------------------------------------------------------------
module ray_quad_hit_test_top (
   input  logic                            clock,
   input  logic                            reset,
   rqht_req_if.sink                        req,
   rqht_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  rqht_pkg::csr_index_type         csr_index,
   input  logic [rqht_pkg::CSR_W-1:0]      csr_wdata
);
   import rqht_pkg::*;

   logic [HALF_W-1:0]       hw_ff, hh_ff;
   logic signed [POS_W-1:0] cy_ff, pz_ff;

   logic          adv;
   front_out_type front_out;

   div_stage_type xcell [XY_CELLS+1];
   div_stage_type ycell [XY_CELLS+1];
   logic [XY_CELLS-1:0] vxy_ff;
   xy_side_type         xside_ff [XY_CELLS];

   uv_stage_type  bound_out;
   div_stage_type ucell [UV_CELLS+1];
   div_stage_type vcell [UV_CELLS+1];
   logic [UV_CELLS-1:0] vuv_ff;
   logic [UV_CELLS-1:0] huv_ff;

   logic            pv_take;
   logic [UV_W-1:0] quot_u, quot_v;
   result_type      res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   result_type      rsp_res_ff, skid_res_ff;
   logic            rsp_load;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= HALF_WIDTH_RST;
         hh_ff <= HALF_HEIGHT_RST;
         cy_ff <= CENTER_Y_RST;
         pz_ff <= PLANE_Z_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_WIDTH:  hw_ff <= csr_wdata[HALF_W-1:0];
            CSR_HALF_HEIGHT: hh_ff <= csr_wdata[HALF_W-1:0];
            CSR_CENTER_Y:    cy_ff <= $signed(csr_wdata[POS_W-1:0]);
            CSR_PLANE_Z:     pz_ff <= $signed(csr_wdata[POS_W-1:0]);
            default: ;
         endcase
      end
   end

   // pipeline moves whenever the skid register is free
   assign adv = ~skid_valid_ff;

   rqht_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req       (req),
      .plane_z   (pz_ff),
      .front_out (front_out)
   );

   // x and y division rows
   assign xcell[0] = front_out.divx;
   assign ycell[0] = front_out.divy;

   for (genvar i = 0; i < XY_CELLS; i++) begin : g_xy
      rqht_div_cell u_xcell (
         .clock    (clock),
         .adv      (adv),
         .cell_in  (xcell[i]),
         .cell_out (xcell[i+1])
      );
      rqht_div_cell u_ycell (
         .clock    (clock),
         .adv      (adv),
         .cell_in  (ycell[i]),
         .cell_out (ycell[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vxy_ff <= '0;
      end else if (adv) begin
         vxy_ff <= {vxy_ff[XY_CELLS-2:0], front_out.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xside_ff[0] <= front_out.side;
         for (int i = 1; i < XY_CELLS; i++) begin
            xside_ff[i] <= xside_ff[i-1];
         end
      end
   end

   rqht_bound u_bound (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .xy_valid    (vxy_ff[XY_CELLS-1]),
      .side        (xside_ff[XY_CELLS-1]),
      .quot_x      (xcell[XY_CELLS].word),
      .quot_y      (ycell[XY_CELLS].word),
      .half_width  (hw_ff),
      .half_height (hh_ff),
      .center_y    (cy_ff),
      .bound_out   (bound_out)
   );

   // u and v division rows
   assign ucell[0] = bound_out.divu;
   assign vcell[0] = bound_out.divv;

   for (genvar i = 0; i < UV_CELLS; i++) begin : g_uv
      rqht_div_cell u_ucell (
         .clock    (clock),
         .adv      (adv),
         .cell_in  (ucell[i]),
         .cell_out (ucell[i+1])
      );
      rqht_div_cell u_vcell (
         .clock    (clock),
         .adv      (adv),
         .cell_in  (vcell[i]),
         .cell_out (vcell[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vuv_ff <= '0;
      end else if (adv) begin
         vuv_ff <= {vuv_ff[UV_CELLS-2:0], bound_out.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         huv_ff <= {huv_ff[UV_CELLS-2:0], bound_out.hit};
      end
   end

   // result formatting, v flipped
   assign quot_u = ucell[UV_CELLS].word[UV_W-1:0];
   assign quot_v = vcell[UV_CELLS].word[UV_W-1:0];

   always_comb begin
      res_in.hit   = huv_ff[UV_CELLS-1];
      res_in.tex_u = '0;
      res_in.tex_v = '0;
      if (huv_ff[UV_CELLS-1]) begin
         res_in.tex_u = (hw_ff == '0) ? '0 : quot_u;
         res_in.tex_v = (hh_ff == '0) ? UV_ONE : UV_ONE - quot_v;
      end
   end

   // output register with skid
   assign pv_take  = vuv_ff[UV_CELLS-1] & adv;
   assign rsp_load = ~rsp_valid_ff | rsp.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_load) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = pv_take;
         end
      end else if (pv_take) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_res_ff <= skid_valid_ff ? skid_res_ff : res_in;
      end
      if (pv_take && !rsp_load) begin
         skid_res_ff <= res_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.hit   = rsp_res_ff.hit;
   assign rsp.tex_u = rsp_res_ff.tex_u;
   assign rsp.tex_v = rsp_res_ff.tex_v;

`ifndef SYNTHESIS
   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds data while the output is empty");

   a_skid_blocks_req : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready && vuv_ff[UV_CELLS-1] && req.ready) |=> !req.ready)
      else $error("request accepted although the skid register filled");

   a_miss_zero_uv : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.hit) |-> (rsp.tex_u == '0 && rsp.tex_v == '0))
      else $error("miss response carries nonzero texture coordinates");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !req.ready |=> ($stable(vxy_ff) && $stable(vuv_ff)))
      else $error("pipeline moved while stalled");
`endif

endmodule
